>>> rtl/lzhb_pkg.sv
// ----------------------------------------------------------------------------
// lzhb_pkg
// Shared types and constants for the hash-bucket match finder.
// ----------------------------------------------------------------------------
package lzhb_pkg;

	typedef enum logic [1:0] {
		FUNC_START  = 2'd0,
		FUNC_APPEND = 2'd1,
		FUNC_FIND   = 2'd2,
		FUNC_SKIP   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		CFG_MIN_LEN  = 2'd0,
		CFG_MAX_LEN  = 2'd1,
		CFG_NICE_LEN = 2'd2
	} cfg_reg_t;

	localparam logic [15:0] MIN_FLOOR    = 16'd3;
	localparam logic [15:0] NICE_DEFAULT = 16'd24;
	localparam logic [15:0] MIN_RESET    = 16'd3;
	localparam logic [15:0] MAX_RESET    = 16'd32768;
	localparam logic [15:0] NICE_RESET   = 16'd24;
	localparam logic [15:0] POS_EMPTY    = 16'hFFFF;
	localparam logic [15:0] POS_START    = 16'hFFFE;
	localparam int          RESULT_CAP   = 32;

endpackage

>>> rtl/lz_hash_bucket_match_finder_top.sv
// ----------------------------------------------------------------------------
// lz_hash_bucket_match_finder_top
// LZ77 match finder over a byte window with per-bucket rings of positions.
// ----------------------------------------------------------------------------
// Load a window with a start word (func 0) and append words (func 1), then
// send one find (func 2) or skip (func 3) word per position with its hash
// bucket. A find returns one or more output words, the final one marked by
// tlast; a word with tuser low carries no match. Timing: after reset and
// after every start word the block sweeps all HASH_BUCKETS bucket heads, one
// per cycle, and takes no input meanwhile. A find or skip runs setup; a find
// then compares each ring slot visited one byte per step, as the single
// byte comparator reads both window bytes from one memory each step; both
// end with the insert. Up to SLOTS_PER_BUCKET slots are visited. A waiting
// output word stalls the walk.
// HASH_BUCKETS and SLOTS_PER_BUCKET must be powers of two.
// ----------------------------------------------------------------------------
module lz_hash_bucket_match_finder_top #(
	parameter int WINDOW_SIZE      = 32768,
	parameter int HASH_BUCKETS     = 4096,
	parameter int SLOTS_PER_BUCKET = 32,
	parameter int MIN_REMAINING    = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // data_byte[7:0], bucket[19:8], zero pad
	input  logic [1:0]  s_axis_tuser,   // func[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // match_len[15:0], match_offset[30:16], zero pad
	output logic        m_axis_tuser,   // has_match
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int AW   = $clog2(WINDOW_SIZE);
	localparam int HBW  = $clog2(HASH_BUCKETS);
	localparam int SBW  = $clog2(SLOTS_PER_BUCKET);
	localparam int STW  = SBW + 1;
	localparam int LEN_CAP = (WINDOW_SIZE < 65535) ? WINDOW_SIZE : 65535;
	localparam int MX_DEF  = (WINDOW_SIZE < 65536) ? WINDOW_SIZE : 65536;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_CHECK, S_SETUP, S_LIMIT, S_PLAN, S_HEAD, S_SLOT_WAIT,
		S_SLOT, S_CMP_A, S_CMP_B, S_JUDGE, S_NEXT, S_INS, S_FIN
	} state_t;

	state_t state_q;

	logic [15:0] min_q, max_q, nice_cfg_q;
	logic [15:0] cur_q, wl_q, rem_q;
	logic [HBW-1:0] bkt_q, clr_cnt_q;
	lzhb_pkg::func_t func_q;
	logic [15:0] mn_q, nice_d_q, max_len_q, nice_len_q, best_q, len_q, prev_q, pos_q;
	logic [16:0] mx_q, nice_q;
	logic [SBW-1:0] idx_q;
	logic [15:0] head_pos_q;
	logic [STW-1:0] steps_q;
	logic [5:0] n_q;
	logic pend_valid_q;
	logic [15:0] pend_len_q;
	logic [14:0] pend_off_q;
	logic out_valid_q, out_has_q, out_last_q;
	logic [15:0] out_len_q;
	logic [14:0] out_off_q;

	// memories
	logic [7:0] win_mem [WINDOW_SIZE];
	logic [SBW+15:0] head_mem [HASH_BUCKETS];
	logic [15:0] slot_mem [HASH_BUCKETS*SLOTS_PER_BUCKET];
	logic [7:0] win_a_q, win_b_q;
	logic [SBW+15:0] head_rd_q;
	logic [15:0] slot_rd_q;

	logic in_acc, out_free, out_push;
	lzhb_pkg::func_t in_func;
	logic [AW-1:0] win_ra, win_rb;
	logic win_we;
	logic head_we;
	logic [HBW-1:0] head_wa;
	logic [SBW+15:0] head_wd;
	logic slot_we;
	logic [SBW-1:0] head_idx, nxt_idx;
	logic [15:0] head_pos, slot_pos, cand_pos;

	assign s_axis_tready = (state_q == S_IDLE);
	assign cfg_ready     = 1'b1;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign in_func       = lzhb_pkg::func_t'(s_axis_tuser);
	assign out_free      = !out_valid_q || m_axis_tready;
	// a new output word is loaded this cycle
	assign out_push      = out_free && ((state_q == S_FIN) ||
		((state_q == S_JUDGE) && (len_q > best_q) && pend_valid_q));

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_off_q, out_len_q};
	assign m_axis_tuser  = out_has_q;
	assign m_axis_tlast  = out_last_q;

	assign head_idx = head_rd_q[SBW+15:16];
	assign head_pos = head_rd_q[15:0];
	assign nxt_idx  = head_idx + SBW'(1);
	assign slot_pos = slot_rd_q;
	assign cand_pos = (idx_q == '0) ? head_pos_q : slot_pos;

	assign win_ra = AW'({1'b0, pos_q} + {1'b0, len_q});
	assign win_rb = AW'({1'b0, cur_q} + {1'b0, len_q});
	assign win_we = in_acc && (in_func == lzhb_pkg::FUNC_APPEND) && (wl_q < 16'(LEN_CAP));

	always_comb begin
		head_we = 1'b0;
		head_wa = bkt_q;
		head_wd = {{SBW{1'b0}}, lzhb_pkg::POS_EMPTY};
		slot_we = 1'b0;
		if (state_q == S_CLEAR) begin
			head_we = 1'b1;
			head_wa = clr_cnt_q;
		end else if (state_q == S_INS) begin
			head_we = 1'b1;
			// slot zero shares the head entry: a wrap to zero replaces its position
			if (nxt_idx == '0) begin
				head_wd = {nxt_idx, cur_q};
			end else begin
				head_wd = {nxt_idx, head_pos};
				slot_we = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (win_we) begin
			win_mem[AW'(wl_q)] <= s_axis_tdata[7:0];
		end
		win_a_q <= win_mem[win_ra];
		win_b_q <= win_mem[win_rb];
	end

	always_ff @(posedge clk) begin
		if (head_we) begin
			head_mem[head_wa] <= head_wd;
		end
		head_rd_q <= head_mem[bkt_q];
	end

	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_mem[{bkt_q, nxt_idx}] <= cur_q;
		end
		slot_rd_q <= slot_mem[{bkt_q, idx_q}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_cnt_q    <= '0;
			min_q        <= lzhb_pkg::MIN_RESET;
			max_q        <= lzhb_pkg::MAX_RESET;
			nice_cfg_q   <= lzhb_pkg::NICE_RESET;
			cur_q        <= '0;
			wl_q         <= '0;
			rem_q        <= '0;
			bkt_q        <= '0;
			func_q       <= lzhb_pkg::FUNC_START;
			mn_q         <= '0;
			mx_q         <= '0;
			nice_d_q     <= '0;
			nice_q       <= '0;
			max_len_q    <= '0;
			nice_len_q   <= '0;
			best_q       <= '0;
			len_q        <= '0;
			prev_q       <= '0;
			pos_q        <= '0;
			idx_q        <= '0;
			head_pos_q   <= '0;
			steps_q      <= '0;
			n_q          <= '0;
			pend_valid_q <= 1'b0;
			pend_len_q   <= '0;
			pend_off_q   <= '0;
			out_valid_q  <= 1'b0;
			out_has_q    <= 1'b0;
			out_last_q   <= 1'b0;
			out_len_q    <= '0;
			out_off_q    <= '0;
		end else begin
			if (out_valid_q && m_axis_tready && !out_push) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid) begin
				unique case (lzhb_pkg::cfg_reg_t'(cfg_index))
					lzhb_pkg::CFG_MIN_LEN:  min_q      <= cfg_data;
					lzhb_pkg::CFG_MAX_LEN:  max_q      <= cfg_data;
					lzhb_pkg::CFG_NICE_LEN: nice_cfg_q <= cfg_data;
					default: ;
				endcase
			end

			unique case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + HBW'(1);
					if (clr_cnt_q == {HBW{1'b1}}) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						func_q <= in_func;
						bkt_q  <= HBW'(s_axis_tdata[19:8]);
						unique case (in_func)
							lzhb_pkg::FUNC_START: begin
								wl_q      <= '0;
								cur_q     <= '0;
								clr_cnt_q <= '0;
								state_q   <= S_CLEAR;
							end
							lzhb_pkg::FUNC_APPEND: begin
								if (win_we) begin
									wl_q <= wl_q + 16'd1;
								end
							end
							default: state_q <= S_CHECK;
						endcase
					end
				end
				S_CHECK: begin
					rem_q <= (wl_q > cur_q) ? (wl_q - cur_q) : 16'd0;
					if ((wl_q <= cur_q) || ((wl_q - cur_q) < 16'(MIN_REMAINING))) begin
						cur_q   <= cur_q + 16'd1;
						state_q <= (func_q == lzhb_pkg::FUNC_FIND) ? S_FIN : S_IDLE;
					end else begin
						state_q <= S_SETUP;
					end
				end
				S_SETUP: begin
					mn_q     <= (min_q < lzhb_pkg::MIN_FLOOR) ? lzhb_pkg::MIN_FLOOR : min_q;
					mx_q     <= (max_q == 16'd0) ? 17'(MX_DEF) : {1'b0, max_q};
					nice_d_q <= (nice_cfg_q == 16'd0) ? lzhb_pkg::NICE_DEFAULT : nice_cfg_q;
					state_q  <= S_LIMIT;
				end
				S_LIMIT: begin
					if (nice_d_q < mn_q) begin
						nice_q <= ({1'b0, mn_q} > mx_q) ? mx_q : {1'b0, mn_q};
					end else begin
						nice_q <= ({1'b0, nice_d_q} > mx_q) ? mx_q : {1'b0, nice_d_q};
					end
					max_len_q <= ({1'b0, rem_q} < mx_q) ? rem_q : mx_q[15:0];
					state_q   <= S_PLAN;
				end
				S_PLAN: begin
					nice_len_q <= (nice_q < {1'b0, max_len_q}) ? nice_q[15:0] : max_len_q;
					best_q     <= mn_q - 16'd1;
					prev_q     <= lzhb_pkg::POS_START;
					steps_q    <= '0;
					n_q        <= '0;
					if ((func_q == lzhb_pkg::FUNC_SKIP) || (mn_q > max_len_q)) begin
						state_q <= S_INS;
					end else begin
						state_q <= S_HEAD;
					end
				end
				S_HEAD: begin
					idx_q      <= head_idx;
					head_pos_q <= head_pos;
					state_q    <= S_SLOT_WAIT;
				end
				S_SLOT_WAIT: begin
					state_q <= S_SLOT;
				end
				S_SLOT: begin
					// positions must keep falling and stay behind the current one
					if ((cand_pos >= prev_q) || (cand_pos >= cur_q)) begin
						state_q <= S_INS;
					end else begin
						prev_q  <= cand_pos;
						pos_q   <= cand_pos;
						len_q   <= '0;
						state_q <= S_CMP_A;
					end
				end
				S_CMP_A: begin
					state_q <= S_CMP_B;
				end
				S_CMP_B: begin
					if ((len_q < max_len_q) && (win_a_q == win_b_q)) begin
						len_q   <= len_q + 16'd1;
						state_q <= S_CMP_A;
					end else begin
						state_q <= S_JUDGE;
					end
				end
				S_JUDGE: begin
					if (len_q > best_q) begin
						// hold the new match until the older one can leave
						if (!pend_valid_q || out_free) begin
							if (pend_valid_q) begin
								out_valid_q <= 1'b1;
								out_has_q   <= 1'b1;
								out_last_q  <= 1'b0;
								out_len_q   <= pend_len_q;
								out_off_q   <= pend_off_q;
							end
							pend_valid_q <= 1'b1;
							pend_len_q   <= len_q;
							pend_off_q   <= 15'(cur_q - pos_q);
							best_q       <= len_q;
							n_q          <= n_q + 6'd1;
							if ((len_q >= nice_len_q) || (n_q == 6'(lzhb_pkg::RESULT_CAP - 1))) begin
								state_q <= S_INS;
							end else begin
								state_q <= S_NEXT;
							end
						end
					end else begin
						state_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					idx_q   <= idx_q - SBW'(1);
					steps_q <= steps_q + STW'(1);
					if (steps_q == STW'(SLOTS_PER_BUCKET - 1)) begin
						state_q <= S_INS;
					end else begin
						state_q <= S_SLOT_WAIT;
					end
				end
				S_INS: begin
					cur_q   <= cur_q + 16'd1;
					state_q <= (func_q == lzhb_pkg::FUNC_FIND) ? S_FIN : S_IDLE;
				end
				S_FIN: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_last_q   <= 1'b1;
						out_has_q    <= pend_valid_q;
						out_len_q    <= pend_valid_q ? pend_len_q : 16'd0;
						out_off_q    <= pend_valid_q ? pend_off_q : 15'd0;
						pend_valid_q <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !s_axis_tready)
		else $error("input taken during head sweep");

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !pend_valid_q)
		else $error("pending match left behind at idle");

	a_nomatch_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tlast && (m_axis_tdata == 32'd0)))
		else $error("no-match word not final or not zero");

	a_fin_pushes_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && out_free) |=> (m_axis_tvalid && m_axis_tlast))
		else $error("find ended without final word");
`endif

endmodule
